// ===== src/grid_neighbour_index_generator_core_defines.svh =====
// Assertion macros shared by the grid neighbour index generator RTL.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef GRID_NEIGHBOUR_INDEX_GENERATOR_CORE_DEFINES_SVH
`define GRID_NEIGHBOUR_INDEX_GENERATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GNIG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GNIG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/gnig_pkg.sv =====
// Shared types, constants and offset tables of the grid neighbour index generator.
// Used by every RTL file of the block; depends on nothing.
package gnig_pkg;

	localparam int COORD_W   = 10;
	localparam int CFG_DIM_W = 11;
	localparam int IDX_W     = 30;
	localparam int CFG_IDX_W = 3;
	localparam int NB_MAX    = 26;
	localparam int NB_FACE   = 6;
	localparam int POS_W     = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIM_X       = 3'd0,
		REG_DIM_Y       = 3'd1,
		REG_DIM_Z       = 3'd2,
		REG_MODE        = 3'd3,
		REG_SLICE_START = 3'd4
	} reg_idx_t;

	// per-axis offset codes
	localparam logic [1:0] OFS_DN   = 2'd0;
	localparam logic [1:0] OFS_ZERO = 2'd1;
	localparam logic [1:0] OFS_UP   = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic [IDX_W-1:0] point_slot;
		logic [IDX_W-1:0] neighbour_index;
		logic             last;
	} nbr_t;

	typedef struct packed {
		logic [1:0] ox;
		logic [1:0] oy;
		logic [1:0] oz;
	} offset_t;

	// which steps stay inside the grid along each axis
	typedef struct packed {
		logic x_lo;
		logic x_hi;
		logic y_lo;
		logic y_hi;
		logic z_lo;
		logic z_hi;
	} axis_ok_t;

	// one queued point: slot, centre index and the neighbours still to emit
	typedef struct packed {
		logic [IDX_W-1:0]  slot;
		logic [IDX_W-1:0]  centre;
		logic [NB_MAX-1:0] mask;
	} work_t;

	localparam offset_t FULL_OFS [NB_MAX] = '{
		'{OFS_DN,   OFS_DN,   OFS_DN},   '{OFS_DN,   OFS_DN,   OFS_ZERO},
		'{OFS_DN,   OFS_DN,   OFS_UP},   '{OFS_DN,   OFS_ZERO, OFS_DN},
		'{OFS_DN,   OFS_ZERO, OFS_ZERO}, '{OFS_DN,   OFS_ZERO, OFS_UP},
		'{OFS_DN,   OFS_UP,   OFS_DN},   '{OFS_DN,   OFS_UP,   OFS_ZERO},
		'{OFS_DN,   OFS_UP,   OFS_UP},
		'{OFS_ZERO, OFS_DN,   OFS_DN},   '{OFS_ZERO, OFS_DN,   OFS_ZERO},
		'{OFS_ZERO, OFS_DN,   OFS_UP},   '{OFS_ZERO, OFS_ZERO, OFS_DN},
		'{OFS_ZERO, OFS_ZERO, OFS_UP},   '{OFS_ZERO, OFS_UP,   OFS_DN},
		'{OFS_ZERO, OFS_UP,   OFS_ZERO}, '{OFS_ZERO, OFS_UP,   OFS_UP},
		'{OFS_UP,   OFS_DN,   OFS_DN},   '{OFS_UP,   OFS_DN,   OFS_ZERO},
		'{OFS_UP,   OFS_DN,   OFS_UP},   '{OFS_UP,   OFS_ZERO, OFS_DN},
		'{OFS_UP,   OFS_ZERO, OFS_ZERO}, '{OFS_UP,   OFS_ZERO, OFS_UP},
		'{OFS_UP,   OFS_UP,   OFS_DN},   '{OFS_UP,   OFS_UP,   OFS_ZERO},
		'{OFS_UP,   OFS_UP,   OFS_UP}
	};

	localparam offset_t FACE_OFS [NB_FACE] = '{
		'{OFS_DN,   OFS_ZERO, OFS_ZERO}, '{OFS_UP,   OFS_ZERO, OFS_ZERO},
		'{OFS_ZERO, OFS_DN,   OFS_ZERO}, '{OFS_ZERO, OFS_UP,   OFS_ZERO},
		'{OFS_ZERO, OFS_ZERO, OFS_DN},   '{OFS_ZERO, OFS_ZERO, OFS_UP}
	};

	// offsets of emission slot pos; unused slots map to the centre
	function automatic offset_t nb_offset(input logic mode, input logic [POS_W-1:0] pos);
		offset_t o;
		o = '{OFS_ZERO, OFS_ZERO, OFS_ZERO};
		if (mode) begin
			if (32'(pos) < NB_MAX) o = FULL_OFS[pos];
		end else begin
			if (32'(pos) < NB_FACE) o = FACE_OFS[pos[2:0]];
		end
		return o;
	endfunction

	function automatic logic step_ok(input logic [1:0] code, input logic lo, input logic hi);
		logic ok;
		ok = 1'b1;
		if (code == OFS_DN) ok = lo;
		if (code == OFS_UP) ok = hi;
		return ok;
	endfunction

endpackage

// ===== src/grid_neighbour_index_generator_core.sv =====
// Top level of the grid neighbour index generator: configuration registers and
// the front end, queue and back end. Depends on gnig_pkg, gnig_front, gnig_fifo, gnig_back.
//
// For each accepted point (x, y, z) the block emits the linear indices
// x + y*dim_x + z*dim_x*dim_y of its in-grid neighbours, one result per cycle
// while nbr_ready takes them: six face neighbours in mode 0 (x-1, x+1, y-1, y+1,
// z-1, z+1) or up to 26 box neighbours in mode 1 (lexicographic x, y, z offsets,
// centre skipped). Each result carries the point's slot (index minus slice start)
// and a last flag; a point without neighbours emits nothing. A point with n
// neighbours occupies the back end, the single result path into the output
// register, until its last result is emitted. The front end keeps accepting
// while the back end works, until the QUEUE_DEPTH-entry queue fills. In the cycle
// after any configuration write the point channel is held off while the plane
// size is recomputed.
module grid_neighbour_index_generator_core #(
	parameter int MAX_AXIS    = 1024,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gnig_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gnig_pkg::IDX_W-1:0]     cfg_data,
	input  logic                           point_valid,
	output logic                           point_ready,
	input  gnig_pkg::point_t               point,
	output logic                           nbr_valid,
	input  logic                           nbr_ready,
	output gnig_pkg::nbr_t                 nbr
);

	localparam int DIM_W   = (MAX_AXIS >= (1 << gnig_pkg::CFG_DIM_W) - 1)
		? gnig_pkg::CFG_DIM_W : $clog2(MAX_AXIS + 1);
	localparam int PLANE_W = 2 * DIM_W;

	logic [DIM_W-1:0]            dim_x_q;
	logic [DIM_W-1:0]            dim_y_q;
	logic [DIM_W-1:0]            dim_z_q;
	logic                        mode_q;
	logic [gnig_pkg::IDX_W-1:0]  slice_q;
	logic [PLANE_W-1:0]          plane_q;
	logic                        pend_q;
	logic                        cfg_we;

	logic                        push;
	gnig_pkg::work_t             push_data;
	logic                        pop;
	gnig_pkg::work_t             head;
	logic                        full;
	logic                        empty;

	// zero reads as one, anything above MAX_AXIS saturates
	function automatic logic [DIM_W-1:0] eff_dim(input logic [gnig_pkg::CFG_DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = DIM_W'(d);
		if (d == '0) r = DIM_W'(1);
		else if (32'(d) > MAX_AXIS) r = DIM_W'(MAX_AXIS);
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= DIM_W'(1);
			dim_y_q <= DIM_W'(1);
			dim_z_q <= DIM_W'(1);
			mode_q  <= 1'b0;
			slice_q <= '0;
			plane_q <= PLANE_W'(1);
			pend_q  <= 1'b0;
		end else begin
			pend_q  <= cfg_we;
			plane_q <= PLANE_W'(dim_x_q) * PLANE_W'(dim_y_q);
			if (cfg_we) begin
				case (cfg_index)
					gnig_pkg::REG_DIM_X: begin
						dim_x_q <= eff_dim(cfg_data[gnig_pkg::CFG_DIM_W-1:0]);
					end
					gnig_pkg::REG_DIM_Y: begin
						dim_y_q <= eff_dim(cfg_data[gnig_pkg::CFG_DIM_W-1:0]);
					end
					gnig_pkg::REG_DIM_Z: begin
						dim_z_q <= eff_dim(cfg_data[gnig_pkg::CFG_DIM_W-1:0]);
					end
					gnig_pkg::REG_MODE: begin
						mode_q <= cfg_data[0];
					end
					gnig_pkg::REG_SLICE_START: begin
						slice_q <= cfg_data;
					end
					default: begin
						// drop writes beyond the register list
					end
				endcase
			end
		end
	end

	gnig_front #(
		.DIM_W(DIM_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point      (point),
		.dim_x      (dim_x_q),
		.dim_y      (dim_y_q),
		.dim_z      (dim_z_q),
		.plane      (plane_q),
		.mode       (mode_q),
		.slice_start(slice_q),
		.hold       (pend_q),
		.full       (full),
		.push       (push),
		.push_data  (push_data)
	);

	gnig_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	gnig_back #(
		.DIM_W(DIM_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.dim_x    (dim_x_q),
		.plane    (plane_q),
		.mode     (mode_q),
		.nbr_valid(nbr_valid),
		.nbr_ready(nbr_ready),
		.nbr      (nbr)
	);

endmodule

// ===== src/gnig_front.sv =====
// Front end: accepts points, forms centre index, slot and neighbour mask in three stages.
// Depends on gnig_pkg; feeds gnig_fifo.
module gnig_front #(
	parameter int DIM_W = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       point_valid,
	output logic                       point_ready,
	input  gnig_pkg::point_t           point,
	input  logic [DIM_W-1:0]           dim_x,
	input  logic [DIM_W-1:0]           dim_y,
	input  logic [DIM_W-1:0]           dim_z,
	input  logic [2*DIM_W-1:0]         plane,
	input  logic                       mode,
	input  logic [gnig_pkg::IDX_W-1:0] slice_start,
	input  logic                       hold,
	input  logic                       full,
	output logic                       push,
	output gnig_pkg::work_t            push_data
);

	localparam int PLANE_W = 2 * DIM_W;
	localparam int YP_W    = gnig_pkg::COORD_W + DIM_W;
	localparam int ZP_W    = gnig_pkg::COORD_W + PLANE_W;
	localparam int CMP_W   = gnig_pkg::CFG_DIM_W + 1;

	logic adv;

	logic                                v_s1;
	gnig_pkg::point_t                    pt_s1;
	logic                                v_s2;
	logic [gnig_pkg::COORD_W-1:0]        x_s2;
	logic [YP_W-1:0]                     yprod_s2;
	logic [gnig_pkg::IDX_W-1:0]          zprod_s2;
	gnig_pkg::axis_ok_t                  ok_s2;
	logic                                v_s3;
	logic [gnig_pkg::IDX_W-1:0]          centre_s3;
	gnig_pkg::axis_ok_t                  ok_s3;

	logic [YP_W-1:0]                     yprod;
	logic [ZP_W-1:0]                     zprod;
	gnig_pkg::axis_ok_t                  ok;
	logic [gnig_pkg::IDX_W-1:0]          centre;
	logic [gnig_pkg::NB_MAX-1:0]         mask;
	gnig_pkg::offset_t                   ofs;

	// stall the whole front while the last stage cannot hand off
	assign adv         = !v_s3 || !full;
	assign point_ready = adv && !hold;

	always_comb begin
		yprod   = YP_W'(pt_s1.point_y) * YP_W'(dim_x);
		zprod   = ZP_W'(pt_s1.point_z) * ZP_W'(plane);
		ok.x_lo = pt_s1.point_x != '0;
		ok.x_hi = (CMP_W'(pt_s1.point_x) + CMP_W'(1)) < CMP_W'(dim_x);
		ok.y_lo = pt_s1.point_y != '0;
		ok.y_hi = (CMP_W'(pt_s1.point_y) + CMP_W'(1)) < CMP_W'(dim_y);
		ok.z_lo = pt_s1.point_z != '0;
		ok.z_hi = (CMP_W'(pt_s1.point_z) + CMP_W'(1)) < CMP_W'(dim_z);
	end

	assign centre = gnig_pkg::IDX_W'(x_s2) + gnig_pkg::IDX_W'(yprod_s2) + zprod_s2;

	always_comb begin
		mask = '0;
		ofs  = '0;
		for (int p = 0; p < gnig_pkg::NB_MAX; p++) begin
			ofs     = gnig_pkg::nb_offset(mode, gnig_pkg::POS_W'(p));
			mask[p] = (mode || (p < gnig_pkg::NB_FACE))
				&& gnig_pkg::step_ok(ofs.ox, ok_s3.x_lo, ok_s3.x_hi)
				&& gnig_pkg::step_ok(ofs.oy, ok_s3.y_lo, ok_s3.y_hi)
				&& gnig_pkg::step_ok(ofs.oz, ok_s3.z_lo, ok_s3.z_hi);
		end
	end

	// drop points without neighbours here
	assign push             = v_s3 && adv && (mask != '0);
	assign push_data.slot   = centre_s3 - slice_start;
	assign push_data.centre = centre_s3;
	assign push_data.mask   = mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= point_valid && point_ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1     <= point;
			x_s2      <= pt_s1.point_x;
			yprod_s2  <= yprod;
			zprod_s2  <= gnig_pkg::IDX_W'(zprod);
			ok_s2     <= ok;
			centre_s3 <= centre;
			ok_s3     <= ok_s2;
		end
	end

endmodule

// ===== src/gnig_fifo.sv =====
// Short queue of classified points between front and back end.
// Depends on gnig_pkg for the entry type.
module gnig_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gnig_pkg::work_t push_data,
	input  logic            pop,
	output gnig_pkg::work_t head,
	output logic            full,
	output logic            empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gnig_pkg::work_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head  = mem_q[rd_ptr_q];
	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== src/gnig_back.sv =====
// Back end: walks the neighbour mask of the head point into the output register,
// one index per cycle unless nbr_ready stalls it. Depends on gnig_pkg and the assertion macro header.
`include "grid_neighbour_index_generator_core_defines.svh"

module gnig_back #(
	parameter int DIM_W = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gnig_pkg::work_t    head,
	input  logic               empty,
	output logic               pop,
	input  logic [DIM_W-1:0]   dim_x,
	input  logic [2*DIM_W-1:0] plane,
	input  logic               mode,
	output logic               nbr_valid,
	input  logic               nbr_ready,
	output gnig_pkg::nbr_t     nbr
);

	localparam int IW = gnig_pkg::IDX_W;

	logic                         busy_q;
	logic [gnig_pkg::NB_MAX-1:0]  rem_q;
	logic                         nbr_valid_q;
	gnig_pkg::nbr_t               nbr_q;

	logic [gnig_pkg::NB_MAX-1:0]  active;
	logic [gnig_pkg::NB_MAX-1:0]  pick;
	logic [gnig_pkg::NB_MAX-1:0]  rem_next;
	logic [gnig_pkg::POS_W-1:0]   pos;
	gnig_pkg::offset_t            ofs;
	logic [IW-1:0]                tx;
	logic [IW-1:0]                ty;
	logic [IW-1:0]                tz;
	logic [IW-1:0]                idx;
	logic                         emit;

	assign active   = busy_q ? rem_q : head.mask;
	assign pick     = active & (~active + gnig_pkg::NB_MAX'(1));
	assign rem_next = active & ~pick;

	always_comb begin
		pos = '0;
		for (int i = 0; i < gnig_pkg::NB_MAX; i++) begin
			if (pick[i]) pos = gnig_pkg::POS_W'(i);
		end
	end

	always_comb begin
		ofs = gnig_pkg::nb_offset(mode, pos);
		tx  = '0;
		ty  = '0;
		tz  = '0;
		if (ofs.ox == gnig_pkg::OFS_UP) tx = IW'(1);
		if (ofs.ox == gnig_pkg::OFS_DN) tx = '1;
		if (ofs.oy == gnig_pkg::OFS_UP) ty = IW'(dim_x);
		if (ofs.oy == gnig_pkg::OFS_DN) ty = -IW'(dim_x);
		if (ofs.oz == gnig_pkg::OFS_UP) tz = IW'(plane);
		if (ofs.oz == gnig_pkg::OFS_DN) tz = -IW'(plane);
		idx = head.centre + tx + ty + tz;
	end

	assign emit      = !empty && (!nbr_valid_q || nbr_ready);
	// release the queue entry with its final neighbour
	assign pop       = emit && (rem_next == '0);
	assign nbr_valid = nbr_valid_q;
	assign nbr       = nbr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			nbr_valid_q <= 1'b0;
		end else begin
			if (emit) busy_q <= rem_next != '0;
			if (emit) nbr_valid_q <= 1'b1;
			else if (nbr_ready) nbr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rem_q                 <= rem_next;
			nbr_q.point_slot      <= head.slot;
			nbr_q.neighbour_index <= idx;
			nbr_q.last            <= rem_next == '0;
		end
	end

	`GNIG_ASSERT_NOW(a_pick_onehot, clk, arst_n, emit, $onehot(pick), "emit without single pick")
	`GNIG_ASSERT_NOW(a_busy_has_work, clk, arst_n, busy_q, (rem_q != '0) && !empty, "busy with no work")
	`GNIG_ASSERT_NEXT(a_partial_stays, clk, arst_n, emit && !pop, busy_q, "point left early")
	`GNIG_ASSERT_NEXT(a_pop_marks_last, clk, arst_n, pop, nbr_valid_q && nbr_q.last, "pop without last")

endmodule
